>>> rtl/qau_pkg.sv
// Shared operation codes, payload types and limits of the quaternion arithmetic unit.
`default_nettype none

package qau_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_SUB   = 4'd1;
    localparam logic [3:0] FN_NEG   = 4'd2;
    localparam logic [3:0] FN_SCALE = 4'd3;
    localparam logic [3:0] FN_DIVS  = 4'd4;
    localparam logic [3:0] FN_PROD  = 4'd5;
    localparam logic [3:0] FN_CONJ  = 4'd6;
    localparam logic [3:0] FN_INV   = 4'd7;
    localparam logic [3:0] FN_NORM  = 4'd8;
    localparam logic [3:0] FN_NORM2 = 4'd9;
    localparam logic [3:0] FN_NRMLZ = 4'd10;

    // Saturation limits of one 32-bit component.
    localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // Four components, index 0 is w, then x, y, z.
    typedef logic [3:0][31:0] t_quat;

    // Item state carried past the multiply and accumulate stages.
    typedef struct packed {
        logic [3:0]  func;
        t_quat       a;
        logic [31:0] c;
        t_quat       r;        // rounded and saturated sums of products
        logic        ovf;      // any component of r saturated
        logic [31:0] n2;       // rounded squared norm of a, clamped
        logic        n2_ovf;
        logic        s_big;    // exact sum of squares reached 2^64
        logic [31:0] nrm;      // rounded norm of a, clamped
        logic        nrm_ovf;
    } t_pl;

    // Final result of one item.
    typedef struct packed {
        t_quat r;
        logic  ovf;
        logic  dz;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/qau_mac.sv
// Operand selection, sixteen multipliers, two adder levels and rounding with saturation.
`default_nettype none

module qau_mac
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [3:0]  i_func,
    input  t_quat       i_a,
    input  t_quat       i_b,
    input  logic [31:0] i_c,
    output logic        o_valid,
    output t_pl         o_pl,
    output logic [63:0] o_sq
);

    localparam logic [31:0]        ONE     = 32'd1 << FRAC_BITS;
    localparam logic signed [65:0] HALF    = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // Stage 1: operand pairs and signs for every term.
    logic signed [31:0] n_s1_x   [4][4];
    logic signed [31:0] n_s1_y   [4][4];
    logic               n_s1_neg [4][4];
    logic signed [31:0] r_s1_x   [4][4];
    logic signed [31:0] r_s1_y   [4][4];
    logic               r_s1_neg [4][4];
    logic               r_s1_valid;
    logic [3:0]         r_s1_func;
    t_quat              r_s1_a;
    logic [31:0]        r_s1_c;

    // Stage 2: products.
    logic signed [63:0] r_s2_p   [4][4];
    logic               r_s2_neg [4][4];
    logic               r_s2_valid;
    logic [3:0]         r_s2_func;
    t_quat              r_s2_a;
    logic [31:0]        r_s2_c;

    // Stage 3: pair sums.
    logic signed [64:0] r_s3_q [4][2];
    logic               r_s3_valid;
    logic [3:0]         r_s3_func;
    t_quat              r_s3_a;
    logic [31:0]        r_s3_c;

    // Stage 4: exact row sums.
    logic signed [65:0] r_s4_s [4];
    logic               r_s4_valid;
    logic [3:0]         r_s4_func;
    t_quat              r_s4_a;
    logic [31:0]        r_s4_c;

    // Stage 5: rounded rows.
    logic signed [65:0] w_v   [4];
    logic [31:0]        w_sat [4];
    logic               w_ovf [4];
    t_pl                n_s5_pl;
    t_pl                r_s5_pl;
    logic [63:0]        r_s5_sq;
    logic               r_s5_valid;

    // Each operation is written as signed sums of products; plain copies use 1.0 as factor.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_s1_x[i][j]   = '0;
                n_s1_y[i][j]   = '0;
                n_s1_neg[i][j] = 1'b0;
            end
        end
        case (i_func)
            FN_ADD, FN_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    n_s1_x[i][0]   = $signed(i_a[i]);
                    n_s1_y[i][0]   = $signed(ONE);
                    n_s1_x[i][1]   = $signed(i_b[i]);
                    n_s1_y[i][1]   = $signed(ONE);
                    n_s1_neg[i][1] = (i_func == FN_SUB);
                end
            end
            FN_NEG, FN_CONJ: begin
                for (int i = 0; i < 4; i++) begin
                    n_s1_x[i][0]   = $signed(i_a[i]);
                    n_s1_y[i][0]   = $signed(ONE);
                    n_s1_neg[i][0] = (i_func == FN_NEG) || (i != 0);
                end
            end
            FN_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    n_s1_x[i][0] = $signed(i_a[i]);
                    n_s1_y[i][0] = $signed(i_c);
                end
            end
            FN_PROD: begin
                // Hamilton product, the last three terms of w and the last term of x, y, z subtract.
                n_s1_x[0][0] = $signed(i_a[0]); n_s1_y[0][0] = $signed(i_b[0]);
                n_s1_x[0][1] = $signed(i_a[1]); n_s1_y[0][1] = $signed(i_b[1]);
                n_s1_x[0][2] = $signed(i_a[2]); n_s1_y[0][2] = $signed(i_b[2]);
                n_s1_x[0][3] = $signed(i_a[3]); n_s1_y[0][3] = $signed(i_b[3]);
                n_s1_neg[0][1] = 1'b1;
                n_s1_neg[0][2] = 1'b1;
                n_s1_neg[0][3] = 1'b1;
                n_s1_x[1][0] = $signed(i_a[0]); n_s1_y[1][0] = $signed(i_b[1]);
                n_s1_x[1][1] = $signed(i_a[1]); n_s1_y[1][1] = $signed(i_b[0]);
                n_s1_x[1][2] = $signed(i_a[2]); n_s1_y[1][2] = $signed(i_b[3]);
                n_s1_x[1][3] = $signed(i_a[3]); n_s1_y[1][3] = $signed(i_b[2]);
                n_s1_neg[1][3] = 1'b1;
                n_s1_x[2][0] = $signed(i_a[0]); n_s1_y[2][0] = $signed(i_b[2]);
                n_s1_x[2][1] = $signed(i_a[2]); n_s1_y[2][1] = $signed(i_b[0]);
                n_s1_x[2][2] = $signed(i_a[3]); n_s1_y[2][2] = $signed(i_b[1]);
                n_s1_x[2][3] = $signed(i_a[1]); n_s1_y[2][3] = $signed(i_b[3]);
                n_s1_neg[2][3] = 1'b1;
                n_s1_x[3][0] = $signed(i_a[0]); n_s1_y[3][0] = $signed(i_b[3]);
                n_s1_x[3][1] = $signed(i_a[3]); n_s1_y[3][1] = $signed(i_b[0]);
                n_s1_x[3][2] = $signed(i_a[1]); n_s1_y[3][2] = $signed(i_b[2]);
                n_s1_x[3][3] = $signed(i_a[2]); n_s1_y[3][3] = $signed(i_b[1]);
                n_s1_neg[3][3] = 1'b1;
            end
            FN_INV, FN_NORM, FN_NORM2, FN_NRMLZ: begin
                // Sum of squares in the w row.
                for (int j = 0; j < 4; j++) begin
                    n_s1_x[0][j] = $signed(i_a[j]);
                    n_s1_y[0][j] = $signed(i_a[j]);
                end
            end
            default: begin
            end
        endcase
    end

    // Valid bits of the five stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // Datapath registers of the first four stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_func <= i_func;
            r_s1_a    <= i_a;
            r_s1_c    <= i_c;
            r_s2_func <= r_s1_func;
            r_s2_a    <= r_s1_a;
            r_s2_c    <= r_s1_c;
            r_s3_func <= r_s2_func;
            r_s3_a    <= r_s2_a;
            r_s3_c    <= r_s2_c;
            r_s4_func <= r_s3_func;
            r_s4_a    <= r_s3_a;
            r_s4_c    <= r_s3_c;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_s1_x[i][j]   <= n_s1_x[i][j];
                    r_s1_y[i][j]   <= n_s1_y[i][j];
                    r_s1_neg[i][j] <= n_s1_neg[i][j];
                    r_s2_p[i][j]   <= r_s1_x[i][j] * r_s1_y[i][j];
                    r_s2_neg[i][j] <= r_s1_neg[i][j];
                end
                for (int h = 0; h < 2; h++) begin
                    r_s3_q[i][h] <=
                        (r_s2_neg[i][2*h] ? -65'(r_s2_p[i][2*h]) : 65'(r_s2_p[i][2*h])) +
                        (r_s2_neg[i][2*h+1] ? -65'(r_s2_p[i][2*h+1])
                                            : 65'(r_s2_p[i][2*h+1]));
                end
                r_s4_s[i] <= 66'(r_s3_q[i][0]) + 66'(r_s3_q[i][1]);
            end
        end
    end

    // Round to nearest with ties upward, then clamp to 32 bits.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_v[i] = (r_s4_s[i] + HALF) >>> FRAC_BITS;
            if (w_v[i] > SAT_MAX) begin
                w_sat[i] = WORD_MAX;
                w_ovf[i] = 1'b1;
            end else if (w_v[i] < SAT_MIN) begin
                w_sat[i] = WORD_MIN;
                w_ovf[i] = 1'b1;
            end else begin
                w_sat[i] = w_v[i][31:0];
                w_ovf[i] = 1'b0;
            end
        end
        n_s5_pl         = '0;
        n_s5_pl.func    = r_s4_func;
        n_s5_pl.a       = r_s4_a;
        n_s5_pl.c       = r_s4_c;
        for (int i = 0; i < 4; i++) begin
            n_s5_pl.r[i] = w_sat[i];
        end
        n_s5_pl.ovf     = w_ovf[0] | w_ovf[1] | w_ovf[2] | w_ovf[3];
        n_s5_pl.n2      = w_sat[0];
        n_s5_pl.n2_ovf  = w_ovf[0];
        n_s5_pl.s_big   = r_s4_s[0][64];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_pl <= n_s5_pl;
            r_s5_sq <= r_s4_s[0][63:0];
        end
    end

    assign o_valid = r_s5_valid;
    assign o_pl    = r_s5_pl;
    assign o_sq    = r_s5_sq;

endmodule

`default_nettype wire

>>> rtl/qau_sqrt.sv
// Pipelined integer square root, one root bit per stage, then rounding and clamping.
`default_nettype none

module qau_sqrt
    import qau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_pl         i_pl,
    input  logic [63:0] i_sq,
    output logic        o_valid,
    output t_pl         o_pl
);

    localparam int STEPS = 32;

    logic        r_v    [STEPS];
    t_pl         r_pl   [STEPS];
    logic [33:0] r_rem  [STEPS];
    logic [31:0] r_root [STEPS];
    logic [63:0] r_xs   [STEPS];

    logic [32:0] w_rnd;
    t_pl         n_out_pl;
    t_pl         r_out_pl;
    logic        r_out_v;

    // Restoring square root: two radicand bits enter each stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic        w_v;
        t_pl         w_pl;
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_xs;
        logic [35:0] w_cat;
        logic [35:0] w_trial;

        if (k == 0) begin : g_head
            assign w_v    = i_valid;
            assign w_pl   = i_pl;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_xs   = i_sq;
        end else begin : g_body
            assign w_v    = r_v[k-1];
            assign w_pl   = r_pl[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_xs   = r_xs[k-1];
        end

        assign w_cat   = {w_rem, w_xs[63:62]};
        assign w_trial = {2'b00, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pl[k] <= w_pl;
                r_xs[k] <= {w_xs[61:0], 2'b00};
                if (w_cat >= w_trial) begin
                    r_rem[k]  <= 34'(w_cat - w_trial);
                    r_root[k] <= {w_root[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cat[33:0];
                    r_root[k] <= {w_root[30:0], 1'b0};
                end
            end
        end
    end

    // Round up when the remainder exceeds the root, clamp a norm above the word range.
    always_comb begin
        w_rnd    = {1'b0, r_root[STEPS-1]} +
                   33'(r_rem[STEPS-1] > {2'b00, r_root[STEPS-1]});
        n_out_pl = r_pl[STEPS-1];
        if (r_pl[STEPS-1].s_big || (w_rnd > {1'b0, WORD_MAX})) begin
            n_out_pl.nrm     = WORD_MAX;
            n_out_pl.nrm_ovf = 1'b1;
        end else begin
            n_out_pl.nrm     = w_rnd[31:0];
            n_out_pl.nrm_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_pl <= n_out_pl;
        end
    end

    assign o_valid = r_out_v;
    assign o_pl    = r_out_pl;

endmodule

`default_nettype wire

>>> rtl/qau_div.sv
// Four-lane pipelined divider, one quotient bit per stage, and the final result select.
`default_nettype none

module qau_div
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_pl  i_pl,
    output logic o_valid,
    output t_res o_res
);

    // Scaled numerator width and number of quotient bits, one bit worked out per stage.
    localparam int NW = 32 + FRAC_BITS;
    localparam int QB = 33;

    // Setup stage: divisor and lane magnitudes.
    logic [31:0] n_d0_d;
    logic        n_d0_dneg;
    logic [31:0] n_d0_mag  [4];
    logic        n_d0_nneg [4];
    logic        r_d0_v;
    t_pl         r_d0_pl;
    logic [31:0] r_d0_d;
    logic [31:0] r_d0_mag  [4];
    logic        r_d0_negr [4];

    // Second setup stage: rounding offset, overflow check, first partial remainder.
    logic [NW-1:0] w_n [4];
    logic          r_d1_v;
    t_pl           r_d1_pl;
    logic [31:0]   r_d1_d;
    logic          r_d1_negr [4];
    logic          r_d1_big  [4];
    logic [31:0]   r_d1_rem  [4];
    logic [QB-1:0] r_d1_low  [4];

    // Quotient stages.
    logic          r_v    [QB];
    t_pl           r_pl   [QB];
    logic [31:0]   r_d    [QB];
    logic          r_negr [QB][4];
    logic          r_big  [QB][4];
    logic [31:0]   r_rem  [QB][4];
    logic [QB-1:0] r_low  [QB][4];
    logic [QB-1:0] r_q    [QB][4];

    // Result stage.
    logic [31:0] w_quo [4];
    logic        w_qov [4];
    t_res        n_res;
    t_res        r_res;
    logic        r_res_v;

    // Pick divisor and numerator signs from the operation.
    always_comb begin
        n_d0_d    = '0;
        n_d0_dneg = 1'b0;
        case (i_pl.func)
            FN_DIVS: begin
                n_d0_d    = i_pl.c[31] ? 32'(-i_pl.c) : i_pl.c;
                n_d0_dneg = i_pl.c[31];
            end
            FN_INV: begin
                n_d0_d = i_pl.n2;
            end
            FN_NRMLZ: begin
                n_d0_d = i_pl.nrm;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            n_d0_mag[i] = i_pl.a[i][31] ? 32'(-i_pl.a[i]) : i_pl.a[i];
            if ((i_pl.func == FN_INV) && (i != 0)) begin
                // The inverse divides the conjugate, so vector signs flip.
                n_d0_nneg[i] = !i_pl.a[i][31] && (i_pl.a[i] != '0);
            end else begin
                n_d0_nneg[i] = i_pl.a[i][31];
            end
        end
    end

    // Scaled numerator plus half the divisor; a quotient of 2^33 or more saturates.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_n[i] = {r_d0_mag[i], {FRAC_BITS{1'b0}}} + NW'(r_d0_d >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_v <= 1'b0;
            r_d1_v <= 1'b0;
        end else if (i_en) begin
            r_d0_v <= i_valid;
            r_d1_v <= r_d0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0_pl <= i_pl;
            r_d0_d  <= n_d0_d;
            r_d1_pl <= r_d0_pl;
            r_d1_d  <= r_d0_d;
            for (int i = 0; i < 4; i++) begin
                r_d0_mag[i]  <= n_d0_mag[i];
                r_d0_negr[i] <= n_d0_nneg[i] ^ n_d0_dneg;
                r_d1_negr[i] <= r_d0_negr[i];
                r_d1_big[i]  <= 32'(w_n[i][NW-1:QB]) >= r_d0_d;
                r_d1_rem[i]  <= 32'(w_n[i][NW-1:QB]);
                r_d1_low[i]  <= w_n[i][QB-1:0];
            end
        end
    end

    // Restoring division, one numerator bit enters each stage.
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic          w_v;
        t_pl           w_pl;
        logic [31:0]   w_d;
        logic          w_negr [4];
        logic          w_big  [4];
        logic [31:0]   w_rem  [4];
        logic [QB-1:0] w_low  [4];
        logic [QB-1:0] w_q    [4];
        logic [32:0]   w_cat  [4];

        if (k == 0) begin : g_head
            assign w_v  = r_d1_v;
            assign w_pl = r_d1_pl;
            assign w_d  = r_d1_d;
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign w_negr[i] = r_d1_negr[i];
                assign w_big[i]  = r_d1_big[i];
                assign w_rem[i]  = r_d1_rem[i];
                assign w_low[i]  = r_d1_low[i];
                assign w_q[i]    = '0;
            end
        end else begin : g_body
            assign w_v  = r_v[k-1];
            assign w_pl = r_pl[k-1];
            assign w_d  = r_d[k-1];
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign w_negr[i] = r_negr[k-1][i];
                assign w_big[i]  = r_big[k-1][i];
                assign w_rem[i]  = r_rem[k-1][i];
                assign w_low[i]  = r_low[k-1][i];
                assign w_q[i]    = r_q[k-1][i];
            end
        end

        for (genvar i = 0; i < 4; i++) begin : g_cat
            assign w_cat[i] = {w_rem[i], w_low[i][QB-1]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pl[k] <= w_pl;
                r_d[k]  <= w_d;
                for (int i = 0; i < 4; i++) begin
                    r_negr[k][i] <= w_negr[i];
                    r_big[k][i]  <= w_big[i];
                    r_low[k][i]  <= {w_low[i][QB-2:0], 1'b0};
                    if (w_cat[i] >= {1'b0, w_d}) begin
                        r_rem[k][i] <= 32'(w_cat[i] - {1'b0, w_d});
                        r_q[k][i]   <= {w_q[i][QB-2:0], 1'b1};
                    end else begin
                        r_rem[k][i] <= w_cat[i][31:0];
                        r_q[k][i]   <= {w_q[i][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Apply the quotient sign and clamp.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_negr[QB-1][i]) begin
                if (r_big[QB-1][i] || (r_q[QB-1][i] > {1'b0, WORD_MIN})) begin
                    w_quo[i] = WORD_MIN;
                    w_qov[i] = 1'b1;
                end else begin
                    w_quo[i] = 32'(-r_q[QB-1][i]);
                    w_qov[i] = 1'b0;
                end
            end else begin
                if (r_big[QB-1][i] || (r_q[QB-1][i] > {1'b0, WORD_MAX})) begin
                    w_quo[i] = WORD_MAX;
                    w_qov[i] = 1'b1;
                end else begin
                    w_quo[i] = r_q[QB-1][i][31:0];
                    w_qov[i] = 1'b0;
                end
            end
        end
    end

    // Select the result of the operation; a zero divisor clears everything but div_zero.
    always_comb begin
        n_res = '0;
        case (r_pl[QB-1].func)
            FN_ADD, FN_SUB, FN_NEG, FN_SCALE, FN_PROD, FN_CONJ: begin
                n_res.r   = r_pl[QB-1].r;
                n_res.ovf = r_pl[QB-1].ovf;
            end
            FN_DIVS, FN_INV, FN_NRMLZ: begin
                if (r_d[QB-1] == '0) begin
                    n_res.dz = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        n_res.r[i] = w_quo[i];
                    end
                    n_res.ovf = w_qov[0] | w_qov[1] | w_qov[2] | w_qov[3] |
                                ((r_pl[QB-1].func == FN_INV) && r_pl[QB-1].n2_ovf) |
                                ((r_pl[QB-1].func == FN_NRMLZ) && r_pl[QB-1].nrm_ovf);
                end
            end
            FN_NORM: begin
                n_res.r[0] = r_pl[QB-1].nrm;
                n_res.ovf  = r_pl[QB-1].nrm_ovf;
            end
            FN_NORM2: begin
                n_res.r[0] = r_pl[QB-1].n2;
                n_res.ovf  = r_pl[QB-1].n2_ovf;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (i_en) begin
            r_res_v <= r_v[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_res_v;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> rtl/quaternion_arith_unit.sv
// Top level of the pipelined Q-format quaternion arithmetic unit.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+----------------------------------------------------------
//  s_axis   | in        | tdata: a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale
//           |           | tuser: func
//  m_axis   | out       | tdata: r_w, r_x, r_y, r_z; tuser: overflow, div_zero
//
// One beat is accepted in every cycle in which the output register is free or being emptied.
// Each beat passes the multiply stages, the 32-stage square root and the 33-stage divider.
// All stages advance together; a held output stops the whole pipeline, and nothing is
// dropped or repeated. Reset clears only the valid bits of the stages.
`default_nettype none

module quaternion_arith_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [287:0] i_s_axis_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale
    input  logic [3:0]   i_s_axis_tuser,   // func
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // r_w, r_x, r_y, r_z
    output logic [1:0]   o_m_axis_tuser    // overflow, div_zero
);

    logic  w_en;
    t_quat w_a;
    t_quat w_b;
    logic  w_mac_valid;
    t_pl   w_mac_pl;
    logic [63:0] w_mac_sq;
    logic  w_sqrt_valid;
    t_pl   w_sqrt_pl;
    logic  w_div_valid;
    t_res  w_res;

    // The pipeline moves whenever the output register is free or being emptied.
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Unpack the input beat.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_a[i] = i_s_axis_tdata[32*i +: 32];
            w_b[i] = i_s_axis_tdata[128 + 32*i +: 32];
        end
    end

    qau_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_func  (i_s_axis_tuser),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (i_s_axis_tdata[287:256]),
        .o_valid (w_mac_valid),
        .o_pl    (w_mac_pl),
        .o_sq    (w_mac_sq)
    );

    qau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mac_valid),
        .i_pl    (w_mac_pl),
        .i_sq    (w_mac_sq),
        .o_valid (w_sqrt_valid),
        .o_pl    (w_sqrt_pl)
    );

    qau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_valid),
        .i_pl    (w_sqrt_pl),
        .o_valid (w_div_valid),
        .o_res   (w_res)
    );

    // The divider's result register is the output register.
    assign o_m_axis_tvalid = w_div_valid;
    assign o_m_axis_tdata  = w_res.r;
    assign o_m_axis_tuser  = {w_res.dz, w_res.ovf};

    // A zero divisor never reports overflow.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("overflow and div_zero both set");

    // A zero divisor returns all components zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tdata == '0))
        else $error("div_zero result with nonzero components");

    // A stalled pipeline holds the valid bits of its multiply and square-root outputs.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_mac_valid) && $stable(w_sqrt_valid))
        else $error("pipeline stage moved during a stall");

endmodule

`default_nettype wire
